// File: design/running_variance_stdev_unit_macros.svh
// Assertion helpers used by rvs_fifo.
`ifndef RUNNING_VARIANCE_STDEV_UNIT_MACROS_SVH
`define RUNNING_VARIANCE_STDEV_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RVS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rvs assertion failed");
`define RVS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rvs assertion failed");
`else
`define RVS_ASSERT_IMPL(label, ante, cons)
`define RVS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: design/rvs_pkg.sv
`timescale 1ns / 1ps
package rvs_pkg;
   localparam int COUNT_BITS  = 16;
   localparam int COUNT_W     = COUNT_BITS + 1;
   localparam int SUM_W       = 42;
   localparam int SQS_W       = 64;
   localparam int SAMPLE_W    = 24;
   localparam int SQ_W        = 2 * SAMPLE_W;
   localparam int MEAN_W      = 40;
   localparam int VAR_W       = 63;
   localparam int SD_W        = 39;
   localparam int NSQ_W       = 2 * COUNT_BITS;
   localparam int MDIV_W      = SUM_W + 16;
   localparam int PA_W        = SQS_W + COUNT_BITS;
   localparam int MAG_W       = 2 * SUM_W;
   localparam int DIVN_W      = MAG_W + 32;
   localparam int ROOT_W      = DIVN_W / 2;
   localparam int SREM_W      = ROOT_W + 3;
   localparam int STEP_W      = 7;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [COUNT_W-1:0] CNT_MAX = COUNT_W'((1 << COUNT_BITS) - 1);
   localparam logic [COUNT_W-1:0] CNT_MIN = {1'b1, {COUNT_BITS{1'b0}}};

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   typedef enum logic {
      REG_SCALE_ENABLE = 1'b0,
      REG_SCALE_FACTOR = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic        scale_enable;
      logic [31:0] scale_factor;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   vsum;
      logic [SQS_W-1:0]   qsum;
      logic               refused;
   } snap_type;

   typedef enum logic [1:0] {
      F_IDLE, F_MUL, F_SAT, F_UPD
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_PREP, B_MULT, B_MAG, B_DIV, B_VAR, B_SQRT, B_FIN, B_OUT
   } back_state_type;
endpackage

// File: design/running_variance_stdev_unit.sv
`timescale 1ns / 1ps
// A req beat for a positive count passes the front states (F_MUL, F_SAT, F_UPD), pop,
// prep, 58 multiply/mean-divide steps, magnitude, 116 divide steps, variance, 58 root
// steps, finish and output; for a zero or negative count the back goes from pop to output.
// For a positive count the beat rate is set by the 1-bit-per-cycle divider and root;
// otherwise by the front, which takes a new beat only after pushing the last. A two-entry
// queue lets the front accept new beats while the back is busy. Reset (synchronous, active
// high) clears count, sums and config to their defaults.
module running_variance_stdev_unit import rvs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // sample_value
   input  logic [1:0]   req_tuser,   // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // sample_count, mean_value, variance, std_dev, pad
   output logic         rsp_tuser,   // refused
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   logic        scale_enable_ff;
   logic [31:0] scale_factor_ff;
   cfg_type     cfg;
   reg_index_type idx;
   logic        push_valid, push_ready, pop_valid, pop_ready;
   snap_type    push_data, pop_data;
   logic [COUNT_W-1:0] r_count;
   logic [MEAN_W-1:0]  r_mean;
   logic [VAR_W-1:0]   r_var;
   logic [SD_W-1:0]    r_sd;

   assign csr_pready = 1'b1;
   assign idx = reg_index_type'(csr_paddr[2]);
   assign cfg = '{scale_enable: scale_enable_ff, scale_factor: scale_factor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_enable_ff <= 1'b0;
         scale_factor_ff <= 32'd65536;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            REG_SCALE_ENABLE: scale_enable_ff <= csr_pwdata[0];
            REG_SCALE_FACTOR: scale_factor_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SCALE_ENABLE: csr_prdata = {31'b0, scale_enable_ff};
         REG_SCALE_FACTOR: csr_prdata = scale_factor_ff;
         default: csr_prdata = '0;
      endcase
   end

   rvs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .req_sample (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rvs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rvs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_data     (pop_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_count    (r_count),
      .rsp_mean     (r_mean),
      .rsp_variance (r_var),
      .rsp_std_dev  (r_sd),
      .rsp_refused  (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, r_sd, r_var, r_mean, r_count};
endmodule

// File: design/rvs_front.sv
`timescale 1ns / 1ps
module rvs_front import rvs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_sample,
   output logic        push_valid,
   input  logic        push_ready,
   output snap_type    push_data
);
   front_state_type state_ff, state_in;
   logic [1:0]         act_ff, act_in;
   logic               neg_ff, neg_in;
   logic [47:0]        mag_ff, mag_in;
   logic [SAMPLE_W-1:0] v_ff, v_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   vsum_ff, vsum_in;
   logic [SQS_W-1:0]   qsum_ff, qsum_in;
   logic [63:0]        prod;
   logic [SAMPLE_W-1:0] satm;
   logic [COUNT_W-1:0] nxt_count;
   logic [SUM_W-1:0]   nxt_vsum;
   logic [SQS_W-1:0]   nxt_qsum;
   logic               refused;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         count_ff <= '0;
         vsum_ff  <= '0;
         qsum_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         vsum_ff  <= vsum_in;
         qsum_ff  <= qsum_in;
      end
      act_ff <= act_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      v_ff   <= v_in;
      sq_ff  <= sq_in;
   end

   always_comb begin
      prod = 64'(mag_ff[31:0]) * 64'(cfg.scale_factor);
      if (!neg_ff && mag_ff > 48'd8388607) satm = 24'd8388607;
      else if (neg_ff && mag_ff > 48'd8388608) satm = 24'd8388608;
      else satm = mag_ff[SAMPLE_W-1:0];
      nxt_count = count_ff;
      nxt_vsum  = vsum_ff;
      nxt_qsum  = qsum_ff;
      refused   = 1'b0;
      unique case (act_ff)
         ACT_INSERT: begin
            if (count_ff == CNT_MAX) begin
               refused = 1'b1;
            end else begin
               nxt_count = count_ff + COUNT_W'(1);
               nxt_vsum  = vsum_ff + {{(SUM_W-SAMPLE_W){v_ff[SAMPLE_W-1]}}, v_ff};
               nxt_qsum  = qsum_ff + {{(SQS_W-SQ_W){1'b0}}, sq_ff};
            end
         end
         ACT_REMOVE: begin
            if (count_ff != CNT_MIN) begin
               nxt_count = count_ff - COUNT_W'(1);
               nxt_vsum  = vsum_ff - {{(SUM_W-SAMPLE_W){v_ff[SAMPLE_W-1]}}, v_ff};
               nxt_qsum  = qsum_ff - {{(SQS_W-SQ_W){1'b0}}, sq_ff};
            end
         end
         default: ;
      endcase
      push_data = '{count: nxt_count, vsum: nxt_vsum, qsum: nxt_qsum, refused: refused};

      state_in   = state_ff;
      act_in     = act_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      v_in       = v_ff;
      sq_in      = sq_ff;
      count_in   = count_ff;
      vsum_in    = vsum_ff;
      qsum_in    = qsum_ff;
      req_tready = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               act_in   = req_action;
               neg_in   = req_sample[31];
               mag_in   = {16'b0, req_sample[31] ? (~req_sample + 32'd1) : req_sample};
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            if (cfg.scale_enable && cfg.scale_factor != 32'd0) mag_in = prod[63:16];
            state_in = F_SAT;
         end
         F_SAT: begin
            v_in     = neg_ff ? (~satm + SAMPLE_W'(1)) : satm;
            sq_in    = SQ_W'(satm) * SQ_W'(satm);
            state_in = F_UPD;
         end
         F_UPD: begin
            push_valid = 1'b1;
            if (push_ready) begin
               count_in = nxt_count;
               vsum_in  = nxt_vsum;
               qsum_in  = nxt_qsum;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end
endmodule

// File: design/rvs_fifo.sv
`timescale 1ns / 1ps
`include "running_variance_stdev_unit_macros.svh"
module rvs_fifo import rvs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  snap_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output snap_type pop_data
);
   snap_type   mem_ff [QUEUE_DEPTH];
   logic       wptr_ff, rptr_ff;
   logic [1:0] fill_ff;
   logic       push, pop;

   assign push_ready = fill_ff != 2'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != 2'd0;
   assign pop_data   = mem_ff[rptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop) rptr_ff <= ~rptr_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wptr_ff] <= push_data;
   end

   `RVS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= 2'(QUEUE_DEPTH))
   `RVS_ASSERT_IMPL(a_empty_ptrs, fill_ff == 2'd0, wptr_ff == rptr_ff)
   `RVS_ASSERT_NEXT(a_push_grows, !reset && push && !pop, fill_ff == $past(fill_ff) + 2'd1)
   `RVS_ASSERT_NEXT(a_pop_shrinks, !reset && pop && !push, fill_ff == $past(fill_ff) - 2'd1)
endmodule

// File: design/rvs_back.sv
`timescale 1ns / 1ps
module rvs_back import rvs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  snap_type            pop_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [COUNT_W-1:0]  rsp_count,
   output logic [MEAN_W-1:0]   rsp_mean,
   output logic [VAR_W-1:0]    rsp_variance,
   output logic [SD_W-1:0]     rsp_std_dev,
   output logic                rsp_refused
);
   back_state_type state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [COUNT_BITS-1:0] n_ff, n_in, nsh_ff, nsh_in;
   logic [NSQ_W-1:0]     nsq_ff, nsq_in;
   logic                 sneg_ff, sneg_in, qneg_ff, qneg_in, vneg_ff, vneg_in;
   logic [SUM_W-1:0]     smag_ff, smag_in, ssh_ff, ssh_in;
   logic [SQS_W-1:0]     qmag_ff, qmag_in;
   logic [COUNT_BITS-1:0] mrem_ff, mrem_in;
   logic [MDIV_W-1:0]    mq_ff, mq_in;
   logic [PA_W-1:0]      a_ff, a_in;
   logic [MAG_W-1:0]     b_ff, b_in;
   logic [NSQ_W-1:0]     rem_ff, rem_in;
   logic [DIVN_W-1:0]    dq_ff, dq_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [SREM_W-1:0]    srem_ff, srem_in;
   logic [COUNT_W-1:0]   cnt_o_ff, cnt_o_in;
   logic [MEAN_W-1:0]    mean_o_ff, mean_o_in;
   logic [VAR_W-1:0]     var_o_ff, var_o_in;
   logic [SD_W-1:0]      sd_o_ff, sd_o_in;
   logic                 ref_o_ff, ref_o_in;

   logic [COUNT_BITS:0]  mt;
   logic                 mge;
   logic [NSQ_W:0]       dt;
   logic                 dge;
   logic [SREM_W-1:0]    st, trial;
   logic                 sge;
   logic [MAG_W-1:0]     a_ext, mag;
   logic                 age;
   logic [MEAN_W-1:0]    mlim, mr;
   logic [VAR_W-1:0]     vlim, vr;
   logic [DIVN_W-17:0]   vq;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= B_IDLE;
      else state_ff <= state_in;
      step_ff   <= step_in;
      n_ff      <= n_in;
      nsh_ff    <= nsh_in;
      nsq_ff    <= nsq_in;
      sneg_ff   <= sneg_in;
      qneg_ff   <= qneg_in;
      vneg_ff   <= vneg_in;
      smag_ff   <= smag_in;
      ssh_ff    <= ssh_in;
      qmag_ff   <= qmag_in;
      mrem_ff   <= mrem_in;
      mq_ff     <= mq_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      rem_ff    <= rem_in;
      dq_ff     <= dq_in;
      root_ff   <= root_in;
      srem_ff   <= srem_in;
      cnt_o_ff  <= cnt_o_in;
      mean_o_ff <= mean_o_in;
      var_o_ff  <= var_o_in;
      sd_o_ff   <= sd_o_in;
      ref_o_ff  <= ref_o_in;
   end

   assign rsp_count    = cnt_o_ff;
   assign rsp_mean     = mean_o_ff;
   assign rsp_variance = var_o_ff;
   assign rsp_std_dev  = sd_o_ff;
   assign rsp_refused  = ref_o_ff;

   always_comb begin
      mt    = {mrem_ff, mq_ff[MDIV_W-1]};
      mge   = mt >= {1'b0, n_ff};
      dt    = {rem_ff, dq_ff[DIVN_W-1]};
      dge   = dt >= {1'b0, nsq_ff};
      st    = {srem_ff[SREM_W-3:0], dq_ff[DIVN_W-1:DIVN_W-2]};
      trial = {1'b0, root_ff, 2'b01};
      sge   = st >= trial;
      a_ext = {{(MAG_W-PA_W){1'b0}}, a_ff};
      age   = a_ext >= b_ff;
      if (qneg_ff) mag = a_ext + b_ff;
      else if (age) mag = a_ext - b_ff;
      else mag = b_ff - a_ext;
      mlim  = sneg_ff ? {1'b1, {(MEAN_W-1){1'b0}}} : {1'b0, {(MEAN_W-1){1'b1}}};
      mr    = (mq_ff > {{(MDIV_W-MEAN_W){1'b0}}, mlim}) ? mlim : mq_ff[MEAN_W-1:0];
      vq    = dq_ff[DIVN_W-1:16];
      vlim  = vneg_ff ? {1'b1, {(VAR_W-1){1'b0}}} : {1'b0, {(VAR_W-1){1'b1}}};
      vr    = (vq > {{(DIVN_W-16-VAR_W){1'b0}}, vlim}) ? vlim : vq[VAR_W-1:0];

      state_in  = state_ff;
      step_in   = step_ff;
      n_in      = n_ff;
      nsh_in    = nsh_ff;
      nsq_in    = nsq_ff;
      sneg_in   = sneg_ff;
      qneg_in   = qneg_ff;
      vneg_in   = vneg_ff;
      smag_in   = smag_ff;
      ssh_in    = ssh_ff;
      qmag_in   = qmag_ff;
      mrem_in   = mrem_ff;
      mq_in     = mq_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      rem_in    = rem_ff;
      dq_in     = dq_ff;
      root_in   = root_ff;
      srem_in   = srem_ff;
      cnt_o_in  = cnt_o_ff;
      mean_o_in = mean_o_ff;
      var_o_in  = var_o_ff;
      sd_o_in   = sd_o_ff;
      ref_o_in  = ref_o_ff;
      pop_ready  = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cnt_o_in = pop_data.count;
               ref_o_in = pop_data.refused;
               n_in     = pop_data.count[COUNT_BITS-1:0];
               sneg_in  = pop_data.vsum[SUM_W-1];
               smag_in  = pop_data.vsum[SUM_W-1] ? (~pop_data.vsum + SUM_W'(1)) : pop_data.vsum;
               qneg_in  = pop_data.qsum[SQS_W-1];
               qmag_in  = pop_data.qsum[SQS_W-1] ? (~pop_data.qsum + SQS_W'(1)) : pop_data.qsum;
               if (pop_data.count[COUNT_W-1] || pop_data.count == '0) begin
                  mean_o_in = '0;
                  var_o_in  = '0;
                  sd_o_in   = '0;
                  state_in  = B_OUT;
               end else begin
                  state_in = B_PREP;
               end
            end
         end
         B_PREP: begin
            nsq_in   = NSQ_W'(n_ff) * NSQ_W'(n_ff);
            mq_in    = {smag_ff, 16'b0};
            mrem_in  = '0;
            a_in     = '0;
            b_in     = '0;
            nsh_in   = n_ff;
            ssh_in   = smag_ff;
            step_in  = '0;
            state_in = B_MULT;
         end
         B_MULT: begin
            mrem_in = mge ? COUNT_BITS'(mt - {1'b0, n_ff}) : mt[COUNT_BITS-1:0];
            mq_in   = {mq_ff[MDIV_W-2:0], mge};
            if (step_ff < STEP_W'(COUNT_BITS)) begin
               a_in   = {a_ff[PA_W-2:0], 1'b0} +
                        (nsh_ff[COUNT_BITS-1] ? {{COUNT_BITS{1'b0}}, qmag_ff} : '0);
               nsh_in = {nsh_ff[COUNT_BITS-2:0], 1'b0};
            end
            if (step_ff < STEP_W'(SUM_W)) begin
               b_in   = {b_ff[MAG_W-2:0], 1'b0} +
                        (ssh_ff[SUM_W-1] ? {{(MAG_W-SUM_W){1'b0}}, smag_ff} : '0);
               ssh_in = {ssh_ff[SUM_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MDIV_W - 1)) state_in = B_MAG;
         end
         B_MAG: begin
            mean_o_in = sneg_ff ? (~mr + MEAN_W'(1)) : mr;
            vneg_in   = qneg_ff || !age;
            dq_in     = {mag, 32'b0};
            rem_in    = '0;
            step_in   = '0;
            state_in  = B_DIV;
         end
         B_DIV: begin
            rem_in  = dge ? NSQ_W'(dt - {1'b0, nsq_ff}) : dt[NSQ_W-1:0];
            dq_in   = {dq_ff[DIVN_W-2:0], dge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIVN_W - 1)) state_in = B_VAR;
         end
         B_VAR: begin
            var_o_in = vneg_ff ? (~vr + VAR_W'(1)) : vr;
            root_in  = '0;
            srem_in  = '0;
            step_in  = '0;
            state_in = B_SQRT;
         end
         B_SQRT: begin
            srem_in = sge ? (st - trial) : st;
            root_in = {root_ff[ROOT_W-2:0], sge};
            dq_in   = {dq_ff[DIVN_W-3:0], 2'b00};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ROOT_W - 1)) state_in = B_FIN;
         end
         B_FIN: begin
            sd_o_in  = (root_ff > {{(ROOT_W-SD_W){1'b0}}, {SD_W{1'b1}}}) ?
                       {SD_W{1'b1}} : root_ff[SD_W-1:0];
            state_in = B_OUT;
         end
         B_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end
endmodule

// File: bench/running_variance_stdev_unit_tb.sv
`timescale 1ns / 1ps
module running_variance_stdev_unit_tb import rvs_pkg::*;;

   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES = 300;
   localparam int LONG_HOLD = 3000;

   typedef struct {
      logic [1:0]  action;
      logic [31:0] sample;
   } sample_beat_type;

   typedef struct {
      logic [16:0] count;
      logic [39:0] mean;
      logic [62:0] variance;
      logic [38:0] stdev;
      logic        refused;
   } stats_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [159:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   sample_beat_type pending_beats[$];
   stats_type       expected_stats[$];

   logic        scale_on;
   logic [31:0] scale_mult;
   int          tally;
   logic [41:0] running_sum;
   logic [63:0] running_squares;

   int   errors;
   int   sender_gap;
   int   receiver_gap;
   int   hold_cycles;
   int   quiet_cycles;
   bit   quiet;
   bit   sender_paused;
   bit   long_hold_req;
   logic req_took;

   running_variance_stdev_unit u_dut (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic stats_type update_stats(logic [1:0] act, logic [31:0] raw);
      stats_type r;
      logic [63:0] s, mag, v, sq, smag, qmag, m, lim;
      logic [127:0] n, a, b, wmag, nn, vq, dq, c, root;
      logic [41:0] s42;
      bit neg, sneg, qneg, vneg;
      r = '{default: '0};
      s = {{32{raw[31]}}, raw};
      neg = raw[31];
      mag = neg ? -s : s;
      if (scale_on && scale_mult != 0) mag = (mag * {32'd0, scale_mult}) >> 16;
      if (!neg && mag > 64'd8388607) mag = 64'd8388607;
      if (neg && mag > 64'd8388608) mag = 64'd8388608;
      v = neg ? -mag : mag;
      sq = v * v;
      if (act == ACT_INSERT) begin
         if (tally >= 65535) begin
            r.refused = 1'b1;
         end else begin
            tally++;
            running_sum = running_sum + v[41:0];
            running_squares = running_squares + sq;
         end
      end else if (act == ACT_REMOVE) begin
         if (tally > -65536) begin
            tally--;
            running_sum = running_sum - v[41:0];
            running_squares = running_squares - sq;
         end
      end
      r.count = tally[16:0];
      if (tally > 0) begin
         n = tally;
         s42 = running_sum;
         sneg = s42[41];
         smag = sneg ? -{{22{1'b1}}, s42} : {22'd0, s42};
         qneg = running_squares[63];
         qmag = qneg ? -running_squares : running_squares;
         m = (smag << 16) / n[63:0];
         lim = sneg ? (64'd1 << 39) : ((64'd1 << 39) - 1);
         if (m > lim) m = lim;
         r.mean = sneg ? -m[39:0] : m[39:0];
         a = n * {64'd0, qmag};
         b = {64'd0, smag} * {64'd0, smag};
         if (!qneg) begin
            vneg = a < b;
            wmag = vneg ? b - a : a - b;
         end else begin
            vneg = 1'b1;
            wmag = a + b;
         end
         nn = n * n;
         vq = (wmag << 16) / nn;
         lim = vneg ? (64'd1 << 62) : ((64'd1 << 62) - 1);
         if (vq > {64'd0, lim}) vq = {64'd0, lim};
         r.variance = vneg ? -vq[62:0] : vq[62:0];
         dq = (wmag << 32) / nn;
         root = '0;
         for (int i = 63; i >= 0; i--) begin
            c = root | (128'd1 << i);
            if (c * c <= dq) root = c;
         end
         if (root > (128'd1 << 39) - 1) root = (128'd1 << 39) - 1;
         r.stdev = root[38:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      stats_type want;
      stats_type got;
      if (reset) begin
         req_took <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.count = rsp_tdata[16:0];
            got.mean = rsp_tdata[56:17];
            got.variance = rsp_tdata[119:57];
            got.stdev = rsp_tdata[158:120];
            got.refused = rsp_tuser;
            if (expected_stats.size() == 0) begin
               $display("%0t: unexpected beat count=%h", $realtime, got.count);
               errors++;
            end else begin
               want = expected_stats.pop_front();
               if (got.count !== want.count) begin
                  $display("%0t: count exp %h got %h", $realtime, want.count, got.count);
                  errors++;
               end
               if (got.mean !== want.mean) begin
                  $display("%0t: mean exp %h got %h", $realtime, want.mean, got.mean);
                  errors++;
               end
               if (got.variance !== want.variance) begin
                  $display("%0t: variance exp %h got %h", $realtime, want.variance,
                           got.variance);
                  errors++;
               end
               if (got.stdev !== want.stdev) begin
                  $display("%0t: stdev exp %h got %h", $realtime, want.stdev, got.stdev);
                  errors++;
               end
               if (got.refused !== want.refused) begin
                  $display("%0t: refused exp %b got %b", $realtime, want.refused,
                           got.refused);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_stats.push_back(update_stats(req_tuser, req_tdata));
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_psel && csr_penable))
            quiet_cycles <= 0;
         else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("running_variance_stdev_unit_tb: done, errors");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock) begin
      sample_beat_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
         sender_gap <= 0;
      end else if (!req_tvalid || req_took) begin
         if (sender_gap > 0) begin
            req_tvalid <= 1'b0;
            sender_gap <= sender_gap - 1;
         end else if (pending_beats.size() > 0 && !sender_paused) begin
            b = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= b.action;
            req_tdata <= b.sample;
            if (!quiet && $urandom_range(0, 5) == 0) sender_gap <= $urandom_range(1, 17);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         receiver_gap <= 0;
         hold_cycles <= 0;
      end else if (long_hold_req && hold_cycles == 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= LONG_HOLD;
         long_hold_req <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (receiver_gap > 0) begin
         rsp_tready <= 1'b0;
         receiver_gap <= receiver_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) receiver_gap <= $urandom_range(1, 17);
      end
   end

   task automatic queue_beat(logic [1:0] act, logic [31:0] val);
      sample_beat_type b;
      b.action = act;
      b.sample = val;
      pending_beats.push_back(b);
   endtask

   task automatic wait_drained();
      while (pending_beats.size() > 0 || expected_stats.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (idx == REG_SCALE_ENABLE) scale_on = val[0];
      else scale_mult = val;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic queue_random(int num);
      logic [1:0] act;
      logic [31:0] val;
      int pick;
      for (int i = 0; i < num; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) act = ACT_INSERT;
         else if (pick < 78) act = ACT_REMOVE;
         else if (pick < 94) act = ACT_QUERY;
         else act = ACT_SPARE;
         pick = $urandom_range(0, 9);
         if (pick < 4) val = $urandom;
         else if (pick < 7) val = $urandom_range(0, 2000) - 1000;
         else if (pick < 9) val = $urandom_range(0, 33554431) - 16777216;
         else val = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         queue_beat(act, val);
      end
   endtask

   initial begin
      logic [31:0] factors[6];
      logic        enables[6];
      errors = 0;
      quiet = 1'b0;
      sender_paused = 1'b0;
      long_hold_req = 1'b0;
      scale_on = 1'b0;
      scale_mult = 32'h10000;
      tally = 0;
      running_sum = '0;
      running_squares = '0;
      reset = 1'b1;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      queue_beat(ACT_QUERY, 32'd0);
      queue_beat(ACT_REMOVE, 32'd5);
      queue_beat(ACT_REMOVE, 32'hffff_fffd);
      queue_beat(ACT_INSERT, 32'd7);
      queue_beat(ACT_INSERT, 32'h7fffffff);
      queue_beat(ACT_INSERT, 32'h80000000);
      queue_beat(ACT_INSERT, 32'h007fffff);
      queue_beat(ACT_INSERT, 32'hff800000);
      queue_beat(ACT_INSERT, 32'hffffffff);
      queue_beat(ACT_INSERT, 32'd1);
      queue_beat(ACT_SPARE, 32'h12345678);
      queue_beat(ACT_REMOVE, 32'h7fffffff);
      queue_beat(ACT_QUERY, 32'hffffffff);
      queue_beat(ACT_INSERT, 32'd0);
      queue_beat(ACT_REMOVE, 32'h80000000);
      queue_beat(ACT_INSERT, 32'h00800000);
      queue_beat(ACT_INSERT, 32'h7fffffff);
      queue_beat(ACT_INSERT, 32'h7fffffff);
      queue_beat(ACT_QUERY, 32'd0);
      queue_random(170);
      long_hold_req = 1'b1;
      wait_drained();

      enables = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
      factors = '{32'h10000, 32'h1, 32'hffffffff, 32'h8000, 32'h12345, 32'h30000};
      for (int p = 0; p < 6; p++) begin
         write_reg(REG_SCALE_ENABLE, {31'd0, enables[p]});
         write_reg(REG_SCALE_FACTOR, factors[p]);
         if (p == 5) quiet = 1'b1;
         queue_random(85);
         if (p == 1) begin
            sender_paused = 1'b1;
            while (expected_stats.size() > 0 || req_tvalid) @(posedge clock);
            @(negedge clock);
            sender_paused = 1'b0;
         end
         queue_random(85);
         wait_drained();
      end

      if (errors == 0)
         $display("running_variance_stdev_unit_tb: done, clean");
      else
         $display("running_variance_stdev_unit_tb: done, errors");
      $finish;
   end
endmodule
